// ===== hdl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and constants for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int unsigned DEF_CAPACITY  = 1024;
    localparam int unsigned DEF_KEY_WIDTH = 32;
    localparam int unsigned DEF_TAG_WIDTH = 16;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X_ROOT,
        ST_X_LAST,
        ST_UP,
        ST_UP_CMP,
        ST_DN,
        ST_DN_L,
        ST_DN_CMP,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/binary_heap_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Array-based binary heap held in one RAM, insert with sift-up, extract with
// sift-down, max or min order selected by a register.
// ----------------------------------------------------------------------------
// insert writes the new entry at the end of the heap and climbs one level per
// parent compare; extract reads the root, then the last entry, and sifts that
// down; a full insert or an empty extract goes straight to the result state.
// The next item is accepted once the result has gone to the output register.
// one item at a time over the single RAM read port; a stalled result holds it
// reset: heap empty, order_mode max-at-top, output empty; RAM is not cleared.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core
    import bhpq_pkg::*;
#(
    parameter int unsigned CAPACITY  = DEF_CAPACITY,
    parameter int unsigned KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int unsigned TAG_WIDTH = DEF_TAG_WIDTH,
    localparam int unsigned CW = $clog2(CAPACITY + 1),
    localparam int unsigned IB = ((KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8,
    localparam int unsigned OB = ((KEY_WIDTH + TAG_WIDTH + CW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [IB-1:0] s_axis_tdata,   // key, tag
    input  logic          s_axis_tuser,   // op
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OB-1:0] m_axis_tdata,   // out_key, out_tag, fill
    output logic [1:0]    m_axis_tuser    // status
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned EW = KEY_WIDTH + TAG_WIDTH;
    localparam int unsigned XW = AW + 2;

    t_state r_state, n_state;

    logic                 r_order;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_pos, n_pos;
    logic [EW-1:0]        r_cur, n_cur;
    logic [EW-1:0]        r_lft, n_lft;
    logic                 r_has_r, n_has_r;
    t_status              r_stat, n_stat;
    logic [KEY_WIDTH-1:0] r_okey, n_okey;
    logic [TAG_WIDTH-1:0] r_otag, n_otag;

    logic                 r_m_valid, n_m_valid;
    t_status              r_m_stat, n_m_stat;
    logic [KEY_WIDTH-1:0] r_m_key, n_m_key;
    logic [TAG_WIDTH-1:0] r_m_tag, n_m_tag;
    logic [CW-1:0]        r_m_fill, n_m_fill;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic          in_acc;
    logic          out_free;
    logic [XW-1:0] left_x, right_x, count_x;
    logic [AW-1:0] parent;
    logic          up_better, l_better, r_better;
    logic [EW-1:0] best_l;

    function automatic logic ranks_above(input logic mode,
                                         input logic [KEY_WIDTH-1:0] a,
                                         input logic [KEY_WIDTH-1:0] b);
        ranks_above = mode ? (a < b) : (a > b);
    endfunction

    bhpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign left_x  = {1'b0, r_pos, 1'b1};
    assign right_x = left_x + XW'(1);
    assign count_x = XW'(r_count);
    assign parent  = AW'((r_pos - AW'(1)) >> 1);

    assign up_better = ranks_above(r_order, r_cur[KEY_WIDTH-1:0],
                                   ram_rdata[KEY_WIDTH-1:0]);
    assign l_better  = ranks_above(r_order, r_lft[KEY_WIDTH-1:0],
                                   r_cur[KEY_WIDTH-1:0]);
    assign best_l    = l_better ? r_lft : r_cur;
    assign r_better  = r_has_r && ranks_above(r_order, ram_rdata[KEY_WIDTH-1:0],
                                              best_l[KEY_WIDTH-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == OP_INSERT) begin
                        n_state = (r_count == CW'(CAPACITY)) ? ST_DONE : ST_UP;
                    end else begin
                        n_state = (r_count == '0) ? ST_DONE : ST_X_ROOT;
                    end
                end
            end
            ST_X_ROOT: n_state = (r_count == '0) ? ST_DONE : ST_X_LAST;
            ST_X_LAST: n_state = ST_DN;
            ST_UP:     n_state = (r_pos == '0) ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP: n_state = up_better ? ST_UP : ST_DONE;
            ST_DN:     n_state = (left_x >= count_x) ? ST_DONE : ST_DN_L;
            ST_DN_L:   n_state = ST_DN_CMP;
            ST_DN_CMP: n_state = (r_better || l_better) ? ST_DN : ST_DONE;
            ST_DONE:   n_state = out_free ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_lft     = r_lft;
        n_has_r   = r_has_r;
        n_stat    = r_stat;
        n_okey    = r_okey;
        n_otag    = r_otag;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_stat  = r_m_stat;
        n_m_key   = r_m_key;
        n_m_tag   = r_m_tag;
        n_m_fill  = r_m_fill;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_cur;
        ram_raddr = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_stat = STAT_OK;
                    n_okey = '0;
                    n_otag = '0;
                    n_pos  = '0;
                    n_cur  = s_axis_tdata[EW-1:0];
                    if (s_axis_tuser == OP_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_stat = STAT_FULL;
                        end else begin
                            n_pos   = AW'(r_count);
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        // root read goes out at address zero this cycle
                        if (r_count == '0) begin
                            n_stat = STAT_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            ST_X_ROOT: begin
                n_okey    = ram_rdata[KEY_WIDTH-1:0];
                n_otag    = ram_rdata[EW-1:KEY_WIDTH];
                ram_raddr = AW'(r_count);
            end
            ST_X_LAST: begin
                n_cur = ram_rdata;
                n_pos = '0;
            end
            ST_UP: begin
                ram_raddr = parent;
                if (r_pos == '0) begin
                    ram_we = 1'b1;
                end
            end
            ST_UP_CMP: begin
                ram_we = 1'b1;
                if (up_better) begin
                    ram_wdata = ram_rdata;
                    n_pos     = parent;
                end
            end
            ST_DN: begin
                ram_raddr = AW'(left_x);
                if (left_x >= count_x) begin
                    ram_we = 1'b1;
                end
            end
            ST_DN_L: begin
                n_lft     = ram_rdata;
                n_has_r   = (right_x < count_x);
                ram_raddr = AW'(right_x);
            end
            ST_DN_CMP: begin
                ram_we = 1'b1;
                if (r_better) begin
                    ram_wdata = ram_rdata;
                    n_pos     = AW'(right_x);
                end else if (l_better) begin
                    ram_wdata = r_lft;
                    n_pos     = AW'(left_x);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_stat  = r_stat;
                    n_m_key   = r_okey;
                    n_m_tag   = r_otag;
                    n_m_fill  = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_order   <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_lft    <= n_lft;
        r_has_r  <= n_has_r;
        r_stat   <= n_stat;
        r_okey   <= n_okey;
        r_otag   <= n_otag;
        r_m_stat <= n_m_stat;
        r_m_key  <= n_m_key;
        r_m_tag  <= n_m_tag;
        r_m_fill <= n_m_fill;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OB'({r_m_fill, r_m_tag, r_m_key});
    assign m_axis_tuser  = r_m_stat;

endmodule

// ===== hdl/bhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
